>>> rtl/ltdc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltdc_pkg: line tracking drive controller shared definitions
// Mode and command codes, regulator constants and the steering tables.
// ----------------------------------------------------------------------------
package ltdc_pkg;

   localparam int unsigned SENSOR_WIDTH = 8;
   localparam int unsigned COUNT_WIDTH  = 16;
   localparam int unsigned PWM_WIDTH    = 13;
   localparam int unsigned WHEEL_COUNT  = 4;
   localparam int unsigned TARGET_WIDTH = COUNT_WIDTH + 1;
   localparam int unsigned SUM_WIDTH    = 22;

   localparam logic [PWM_WIDTH-1:0]    PWM_MAX     = 13'd6000;
   localparam logic [TARGET_WIDTH-1:0] FRONT_TRIM  = 17'd3;
   localparam logic [TARGET_WIDTH-1:0] FAST_TARGET = 17'd400;
   localparam logic [TARGET_WIDTH-1:0] SLOW_TARGET = 17'd100;
   localparam logic [15:0]             HOLD_TARGET_RESET = 16'd300;

   localparam logic [SENSOR_WIDTH-1:0] CENTRE_MASK = 8'h18;
   localparam logic [SENSOR_WIDTH-1:0] OUTER_MASK  = 8'h81;
   localparam logic [SENSOR_WIDTH-1:0] INNER_MASK  = 8'h3C;

   typedef enum logic [1:0] {
      MODE_FAST_FOLLOW = 2'd0,
      MODE_SLOW_FOLLOW = 2'd1,
      MODE_SPEED_HOLD  = 2'd2,
      MODE_STEER_ONLY  = 2'd3
   } run_mode_type;

   typedef enum logic [1:0] {
      CMD_NONE       = 2'd0,
      CMD_FORWARD    = 2'd1,
      CMD_STOP_LEFT  = 2'd2,
      CMD_STOP_RIGHT = 2'd3
   } drive_cmd_type;

   typedef enum logic [1:0] {
      CSR_RUN_MODE          = 2'd0,
      CSR_HOLD_TARGET_FRONT = 2'd1,
      CSR_HOLD_TARGET_REAR  = 2'd2
   } csr_index_type;

   localparam logic [2:0] DIR_FORWARD = 3'd1;
   localparam logic [2:0] DIR_BACK    = 3'd2;
   localparam logic [2:0] DIR_ALL     = 3'd5;

   typedef logic [WHEEL_COUNT-1:0][PWM_WIDTH-1:0] pwm_quad_type;

   // Position of the first lit sensor in priority order, centre outward.
   function automatic logic [2:0] prio_index(input logic [SENSOR_WIDTH-1:0] seek);
      logic [2:0] idx;
      idx = 3'd0;
      priority if (seek[3]) idx = 3'd0;
      else if (seek[4]) idx = 3'd1;
      else if (seek[2]) idx = 3'd2;
      else if (seek[5]) idx = 3'd3;
      else if (seek[1]) idx = 3'd4;
      else if (seek[6]) idx = 3'd5;
      else if (seek[0]) idx = 3'd6;
      else idx = 3'd7;
      return idx;
   endfunction

   function automatic pwm_quad_type fast_table(input logic [2:0] idx);
      pwm_quad_type q;
      unique case (idx)
         3'd0: q = {13'd1632, 13'd1560, 13'd2183, 13'd2268};
         3'd1: q = {13'd2767, 13'd2495, 13'd1487, 13'd1577};
         3'd2: q = {13'd1632, 13'd1560, 13'd2553, 13'd2805};
         3'd3: q = {13'd3323, 13'd3205, 13'd1487, 13'd1577};
         3'd4: q = {13'd1267, 13'd1192, 13'd2933, 13'd3258};
         3'd5: q = {13'd3945, 13'd3893, 13'd1124, 13'd1204};
         3'd6: q = {13'd967,  13'd792,  13'd3133, 13'd3458};
         default: q = {13'd4145, 13'd4093, 13'd824, 13'd904};
      endcase
      return q;
   endfunction

   function automatic pwm_quad_type slow_table(input logic [2:0] idx);
      pwm_quad_type q;
      unique case (idx)
         3'd0: q = {13'd2495, 13'd2933, 13'd2933, 13'd3258};
         3'd1: q = {13'd3945, 13'd3893, 13'd2183, 13'd2268};
         3'd2: q = {13'd2195, 13'd2633, 13'd3233, 13'd3568};
         3'd3: q = {13'd4245, 13'd4193, 13'd1883, 13'd1968};
         3'd4: q = {13'd1895, 13'd2333, 13'd3533, 13'd3868};
         3'd5: q = {13'd4545, 13'd4493, 13'd1583, 13'd1668};
         3'd6: q = {13'd1595, 13'd2033, 13'd3833, 13'd4168};
         default: q = {13'd4845, 13'd4793, 13'd1283, 13'd1368};
      endcase
      return q;
   endfunction

   function automatic drive_cmd_type fast_cmd(input logic [2:0] idx);
      drive_cmd_type c;
      unique case (idx)
         3'd0, 3'd1:       c = CMD_FORWARD;
         3'd2, 3'd4, 3'd6: c = CMD_STOP_LEFT;
         default:          c = CMD_STOP_RIGHT;
      endcase
      return c;
   endfunction

   // Even priority positions lie on the low sensor side.
   function automatic drive_cmd_type steer_cmd(input logic [2:0] idx);
      return idx[0] ? CMD_STOP_RIGHT : CMD_STOP_LEFT;
   endfunction

   // One regulator step: acc + 4 * (speed - target), held to 0..PWM_MAX.
   function automatic logic [PWM_WIDTH-1:0] acc_step(
      input logic [PWM_WIDTH-1:0]    acc,
      input logic [COUNT_WIDTH-1:0]  speed,
      input logic [TARGET_WIDTH-1:0] target
   );
      logic signed [SUM_WIDTH-1:0] err;
      logic signed [SUM_WIDTH-1:0] sum;
      logic [PWM_WIDTH-1:0]        res;
      err = $signed(SUM_WIDTH'(speed)) - $signed(SUM_WIDTH'(target));
      sum = $signed(SUM_WIDTH'(acc)) + (err <<< 2);
      if (sum < 0) begin
         res = '0;
      end else if (sum > $signed(SUM_WIDTH'(PWM_MAX))) begin
         res = PWM_MAX;
      end else begin
         res = sum[PWM_WIDTH-1:0];
      end
      return res;
   endfunction

endpackage

>>> rtl/line_tracking_drive_controller_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_tracking_drive_controller_unit: line following wheel drive controller
// Turns a line sensor byte and four encoder counts into four compare values,
// a drive command and line flags, once per control tick.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel carries one tick: sensor byte, four encoder counts and
//   the direction mode. The rsp channel returns one beat per tick with the
//   four compare values, the write flag, the drive command and the centred
//   and crossing flags. A beat is taken when valid is high and stall is low.
//   An accepted req beat passes the input register and then the result
//   register before rsp valid. While rsp_stall is low a req beat is taken
//   every cycle and one tick per cycle is sustained; the input register and
//   the result register are the two stages, regulator update between them.
//   When rsp_stall is high the result register holds, the input register
//   fills, and req_stall rises only when both are occupied.
//   The csr port writes run_mode, hold_target_front and hold_target_rear;
//   write it only while no tick is in flight.
//   Synchronous reset empties both stages, clears the wheel accumulators and
//   loads the register reset values (fast follow, targets of 300).
// ----------------------------------------------------------------------------
module line_tracking_drive_controller_unit
   import ltdc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [SENSOR_WIDTH-1:0] req_line_sensors,
   input  logic [COUNT_WIDTH-1:0] req_enc_count_one,
   input  logic [COUNT_WIDTH-1:0] req_enc_count_two,
   input  logic [COUNT_WIDTH-1:0] req_enc_count_three,
   input  logic [COUNT_WIDTH-1:0] req_enc_count_four,
   input  logic [2:0]             req_dir_mode,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [PWM_WIDTH-1:0]   rsp_pwm_one,
   output logic [PWM_WIDTH-1:0]   rsp_pwm_two,
   output logic [PWM_WIDTH-1:0]   rsp_pwm_three,
   output logic [PWM_WIDTH-1:0]   rsp_pwm_four,
   output logic                   rsp_pwm_write,
   output logic [1:0]             rsp_drive_cmd,
   output logic                   rsp_centred,
   output logic                   rsp_crossing,
   input  logic                   csr_write_enable,
   input  logic [1:0]             csr_index,
   input  logic [15:0]            csr_write_data
);

   // Configuration registers
   run_mode_type     run_mode_ff;
   logic [15:0]      hold_front_ff;
   logic [15:0]      hold_rear_ff;

   // Input stage
   logic                                  s1_valid_ff;
   logic [SENSOR_WIDTH-1:0]               s1_sensors_ff;
   logic [WHEEL_COUNT-1:0][COUNT_WIDTH-1:0] s1_enc_ff;
   logic [2:0]                            s1_dir_ff;

   // Wheel accumulators
   pwm_quad_type acc_ff;
   pwm_quad_type acc_in;

   // Result stage
   logic          rsp_valid_ff;
   pwm_quad_type  rsp_pwm_ff;
   pwm_quad_type  rsp_pwm_in;
   logic          rsp_write_ff;
   logic          rsp_write_in;
   drive_cmd_type rsp_cmd_ff;
   drive_cmd_type rsp_cmd_in;
   logic          rsp_centred_ff;
   logic          rsp_centred_in;
   logic          rsp_crossing_ff;
   logic          rsp_crossing_in;

   logic advance;
   logic req_take;

   logic [SENSOR_WIDTH-1:0]                 seek;
   logic                                    hit_found;
   logic [2:0]                              hit_idx;
   logic                                    rev_front;
   logic                                    rev_rear;
   logic [WHEEL_COUNT-1:0][COUNT_WIDTH-1:0] speed;
   logic [TARGET_WIDTH-1:0]                 tgt_front;
   logic [TARGET_WIDTH-1:0]                 tgt_rear;
   pwm_quad_type                            reg_pwm;
   logic                                    run_reg;

   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         run_mode_ff   <= MODE_FAST_FOLLOW;
         hold_front_ff <= HOLD_TARGET_RESET;
         hold_rear_ff  <= HOLD_TARGET_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_RUN_MODE:          run_mode_ff   <= run_mode_type'(csr_write_data[1:0]);
            CSR_HOLD_TARGET_FRONT: hold_front_ff <= csr_write_data;
            CSR_HOLD_TARGET_REAR:  hold_rear_ff  <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_take) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_sensors_ff <= req_line_sensors;
         s1_enc_ff     <= {req_enc_count_four, req_enc_count_three,
                           req_enc_count_two, req_enc_count_one};
         s1_dir_ff     <= req_dir_mode;
      end
   end

   // Tick evaluation
   always_comb begin
      seek      = ~s1_sensors_ff;
      hit_found = |seek;
      hit_idx   = prio_index(seek);
      rev_front = (s1_dir_ff == DIR_BACK) || (s1_dir_ff == DIR_ALL);
      rev_rear  = (s1_dir_ff == DIR_FORWARD) || (s1_dir_ff == DIR_ALL);
      for (int k = 0; k < WHEEL_COUNT; k++) begin
         if ((k < 2) ? rev_front : rev_rear) begin
            speed[k] = COUNT_WIDTH'(0) - s1_enc_ff[k];
         end else begin
            speed[k] = s1_enc_ff[k];
         end
      end

      unique case (run_mode_ff)
         MODE_SPEED_HOLD: begin
            tgt_front = TARGET_WIDTH'(hold_front_ff) + FRONT_TRIM;
            tgt_rear  = TARGET_WIDTH'(hold_rear_ff);
         end
         MODE_SLOW_FOLLOW: begin
            tgt_front = SLOW_TARGET + FRONT_TRIM;
            tgt_rear  = SLOW_TARGET;
         end
         default: begin
            tgt_front = FAST_TARGET + FRONT_TRIM;
            tgt_rear  = FAST_TARGET;
         end
      endcase

      for (int k = 0; k < WHEEL_COUNT; k++) begin
         reg_pwm[k] = acc_step(acc_ff[k], speed[k], (k < 2) ? tgt_front : tgt_rear);
      end

      rsp_centred_in  = (seek & CENTRE_MASK) == CENTRE_MASK;
      rsp_crossing_in = ((seek & OUTER_MASK) != '0) && ((seek & INNER_MASK) != '0);

      run_reg      = 1'b0;
      rsp_write_in = 1'b0;
      rsp_cmd_in   = CMD_NONE;
      rsp_pwm_in   = '0;
      unique case (run_mode_ff)
         MODE_SPEED_HOLD: begin
            run_reg      = 1'b1;
            rsp_write_in = 1'b1;
            rsp_cmd_in   = CMD_FORWARD;
            rsp_pwm_in   = reg_pwm;
         end
         MODE_FAST_FOLLOW: begin
            priority if (rsp_centred_in) begin
               run_reg      = 1'b1;
               rsp_write_in = 1'b1;
               rsp_cmd_in   = CMD_FORWARD;
               rsp_pwm_in   = reg_pwm;
            end else if (hit_found) begin
               rsp_write_in = 1'b1;
               rsp_cmd_in   = fast_cmd(hit_idx);
               rsp_pwm_in   = fast_table(hit_idx);
            end else begin
               rsp_write_in = 1'b0;
            end
         end
         MODE_SLOW_FOLLOW: begin
            priority if (rsp_centred_in) begin
               run_reg      = 1'b1;
               rsp_write_in = 1'b1;
               rsp_pwm_in   = reg_pwm;
            end else if (hit_found) begin
               rsp_write_in = 1'b1;
               rsp_pwm_in   = slow_table(hit_idx);
            end else begin
               rsp_write_in = 1'b0;
            end
         end
         default: begin
            if (hit_found) begin
               rsp_cmd_in = steer_cmd(hit_idx);
            end
         end
      endcase

      acc_in = (advance && run_reg) ? reg_pwm : acc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_pwm_ff      <= rsp_pwm_in;
         rsp_write_ff    <= rsp_write_in;
         rsp_cmd_ff      <= rsp_cmd_in;
         rsp_centred_ff  <= rsp_centred_in;
         rsp_crossing_ff <= rsp_crossing_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pwm_one   = rsp_pwm_ff[0];
   assign rsp_pwm_two   = rsp_pwm_ff[1];
   assign rsp_pwm_three = rsp_pwm_ff[2];
   assign rsp_pwm_four  = rsp_pwm_ff[3];
   assign rsp_pwm_write = rsp_write_ff;
   assign rsp_drive_cmd = rsp_cmd_ff;
   assign rsp_centred   = rsp_centred_ff;
   assign rsp_crossing  = rsp_crossing_ff;

`ifndef SYNTHESIS
   // The accumulators never leave the compare range.
   a_acc_range: assert property (@(posedge clock) disable iff (reset)
      (acc_ff[0] <= PWM_MAX) && (acc_ff[1] <= PWM_MAX) &&
      (acc_ff[2] <= PWM_MAX) && (acc_ff[3] <= PWM_MAX))
      else $error("wheel accumulator above compare range");

   // Compare values that are not new go out as zero.
   a_pwm_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_write_ff) |-> (rsp_pwm_ff == '0))
      else $error("stale compare values on a beat without write");

   // The input side only stalls when both stages hold a tick.
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("input stalled with room in the pipeline");

   // Accumulators change only when a tick moves to the result register.
   a_acc_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(acc_ff))
      else $error("accumulator changed without a tick");
`endif

endmodule
